>>> rtl/dwcw_pkg.sv
// Shared types, constants and helpers for the display window clip writer.
`timescale 1ns / 1ps
`default_nettype none

package dwcw_pkg;

  // Width of on-screen coordinates; the panel is at most 2^COORD_BITS wide and high.
  localparam int unsigned COORD_BITS = 11;
  localparam int unsigned SIZE_BITS  = 12;
  localparam int unsigned WORD_BITS  = 16;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RST  = 12'd800;
  localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RST = 12'd480;

  // Panel command codes
  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  // Configuration register indexes
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  // Input opcodes
  localparam logic OP_AREA  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_PARAM = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_DONE  = 2'd3
  } write_kind_e;

  typedef enum logic {
    JOB_AREA  = 1'b0,
    JOB_PIXEL = 1'b1
  } job_kind_e;

  // Index of the last word of an area command burst (2 x 5 + memory write).
  localparam logic [3:0] AREA_LAST_IDX = 4'd10;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    job_kind_e                kind;
    logic                     has_data;
    logic                     has_done;
    logic [WORD_BITS-1:0]     pixel;
    logic [COORD_BITS-1:0]    col_start;
    logic [COORD_BITS-1:0]    col_end;
    logic [COORD_BITS-1:0]    page_start;
    logic [COORD_BITS-1:0]    page_end;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // Largest valid index for a screen extent: zero acts as one, clamp to 2^COORD_BITS.
  function automatic logic [COORD_BITS-1:0] max_index(input logic [SIZE_BITS-1:0] v);
    logic [16:0] lim;
    logic [16:0] v_ext;
    lim   = 17'(1) << COORD_BITS;
    v_ext = 17'(v);
    if (v == '0) begin
      max_index = '0;
    end else if (v_ext > lim) begin
      max_index = COORD_BITS'(lim - 17'd1);
    end else begin
      max_index = COORD_BITS'(v_ext - 17'd1);
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/display_window_clip_writer_unit.sv
// Top level of the display window clip writer: front, job queue and back.
`timescale 1ns / 1ps
`default_nettype none

// A flush area word (tuser 0) opens a window; pixel words (tuser 1) follow in row order.
// An area wholly off screen, or inverted, is dropped with its pixels and gives no completion.
// Otherwise the area is clipped to the screen and mirrored in both axes, and the block sends
// column set and page set commands with four parameter bytes each, then memory write: eleven
// words on the master side, one per cycle while tready is high. Pixels inside the clip window
// follow as data words, and a done word closes the area after its last pixel; tlast marks the
// final word caused by each input word. The slave side takes one word per cycle while the
// four-entry job queue has room. While tready is high the master side sends one word per
// cycle from its output register and the sustained pixel rate is one per cycle; an area start
// gives eleven words, a closing pixel inside the clip window two and one outside it one.
// Screen size registers: index 0 width, index 1 height, 12 bits; zero acts as one and sizes
// above 2048 act as 2048. Write them only while the block is idle.
module display_window_clip_writer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [11:0] cfg_data_i,
  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] area_left, [31:16] area_top, [47:32] area_right, [63:48] area_bottom,
  // [79:64] pixel_value
  input  wire logic [79:0] s_axis_tdata,
  // [0] opcode
  input  wire logic [0:0]  s_axis_tuser,
  // result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] bus_word
  output logic [15:0]      m_axis_tdata,
  // [1:0] write_kind
  output logic [1:0]       m_axis_tuser,
  // last_of_run
  output logic             m_axis_tlast
);

  logic                   push, pop;
  dwcw_pkg::job_t         push_job, head_job;
  dwcw_pkg::fifo_status_t fifo_status;

  // Classify input words and hold area and cursor state.
  dwcw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .opcode_i      (s_axis_tuser[0]),
    .in_data_i     (s_axis_tdata),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .job_o         (push_job)
  );

  // Decouple the two sides so each can stall on its own.
  dwcw_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_job_o (head_job),
    .status_o   (fifo_status)
  );

  // Expand each job into bus words.
  dwcw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_job_i    (head_job),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_kind_o    (m_axis_tuser),
    .out_word_o    (m_axis_tdata),
    .out_last_o    (m_axis_tlast)
  );

  // The front never queues a job into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && fifo_status.full))
    else $error("job pushed into full queue");

  // The back only retires a job that is present.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && fifo_status.empty))
    else $error("job popped from empty queue");

  // A done word always ends its run and carries a zero bus word.
  a_done_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == dwcw_pkg::KIND_DONE) |->
      (m_axis_tlast && m_axis_tdata == 16'h0000))
    else $error("malformed done word");

  // Retiring a job loads its final word into the output register.
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (m_axis_tvalid && m_axis_tlast))
    else $error("job retired without final word");

endmodule

`default_nettype wire

>>> rtl/dwcw_front.sv
// Front part: accepts input words, tracks the area and cursor, queues jobs.
`timescale 1ns / 1ps
`default_nettype none

module dwcw_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [dwcw_pkg::SIZE_BITS-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          opcode_i,
  input  wire logic [79:0]                   in_data_i,
  input  wire dwcw_pkg::fifo_status_t        fifo_status_i,
  output logic                               push_o,
  output dwcw_pkg::job_t                     job_o
);

  logic [dwcw_pkg::SIZE_BITS-1:0] screen_w_q, screen_h_q;
  logic                           active_q, active_d;
  logic [dwcw_pkg::COORD_BITS-1:0] clip_l_q, clip_t_q, clip_r_q, clip_b_q;
  logic [dwcw_pkg::COORD_BITS-1:0] clip_l_d, clip_t_d, clip_r_d, clip_b_d;
  logic signed [15:0] full_l_q, full_r_q, full_b_q, full_l_d, full_r_d, full_b_d;
  logic signed [15:0] cur_c_q, cur_r_q, cur_c_d, cur_r_d;

  logic [dwcw_pkg::COORD_BITS-1:0] wmax, hmax;
  logic signed [16:0] wmax_s, hmax_s;
  logic signed [15:0] l_in, t_in, r_in, b_in;
  logic signed [16:0] l_s, t_s, r_s, b_s;
  logic               accept, off_screen, in_window, is_last;

  assign l_in = in_data_i[15:0];
  assign t_in = in_data_i[31:16];
  assign r_in = in_data_i[47:32];
  assign b_in = in_data_i[63:48];
  assign l_s  = 17'(l_in);
  assign t_s  = 17'(t_in);
  assign r_s  = 17'(r_in);
  assign b_s  = 17'(b_in);

  assign wmax   = dwcw_pkg::max_index(screen_w_q);
  assign hmax   = dwcw_pkg::max_index(screen_h_q);
  assign wmax_s = $signed(17'(wmax));
  assign hmax_s = $signed(17'(hmax));

  assign in_ready_o = !fifo_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  assign off_screen = (r_in < l_in) || (b_in < t_in) || (r_in < 16'sd0) || (b_in < 16'sd0) ||
                      (l_s > wmax_s) || (t_s > hmax_s);

  assign in_window = (17'(cur_c_q) >= $signed(17'(clip_l_q))) &&
                     (17'(cur_c_q) <= $signed(17'(clip_r_q))) &&
                     (17'(cur_r_q) >= $signed(17'(clip_t_q))) &&
                     (17'(cur_r_q) <= $signed(17'(clip_b_q)));
  assign is_last   = (cur_c_q == full_r_q) && (cur_r_q == full_b_q);

  always_comb begin
    active_d = active_q;
    clip_l_d = clip_l_q;
    clip_t_d = clip_t_q;
    clip_r_d = clip_r_q;
    clip_b_d = clip_b_q;
    full_l_d = full_l_q;
    full_r_d = full_r_q;
    full_b_d = full_b_q;
    cur_c_d  = cur_c_q;
    cur_r_d  = cur_r_q;
    push_o   = 1'b0;
    job_o    = '0;
    job_o.pixel = in_data_i[79:64];

    if (accept) begin
      if (opcode_i == dwcw_pkg::OP_AREA) begin
        active_d = 1'b0;
        if (!off_screen) begin
          clip_l_d = (l_in < 16'sd0) ? '0 : l_in[dwcw_pkg::COORD_BITS-1:0];
          clip_t_d = (t_in < 16'sd0) ? '0 : t_in[dwcw_pkg::COORD_BITS-1:0];
          clip_r_d = (r_s > wmax_s) ? wmax : r_in[dwcw_pkg::COORD_BITS-1:0];
          clip_b_d = (b_s > hmax_s) ? hmax : b_in[dwcw_pkg::COORD_BITS-1:0];
          full_l_d = l_in;
          full_r_d = r_in;
          full_b_d = b_in;
          cur_c_d  = l_in;
          cur_r_d  = t_in;
          active_d = 1'b1;
          push_o   = 1'b1;
          job_o.kind       = dwcw_pkg::JOB_AREA;
          // Mirror both axes: start comes from the far clip edge.
          job_o.col_start  = wmax - clip_r_d;
          job_o.col_end    = wmax - clip_l_d;
          job_o.page_start = hmax - clip_b_d;
          job_o.page_end   = hmax - clip_t_d;
        end
      end else if (active_q) begin
        job_o.kind     = dwcw_pkg::JOB_PIXEL;
        job_o.has_data = in_window;
        job_o.has_done = is_last;
        push_o         = in_window || is_last;
        if (is_last) begin
          active_d = 1'b0;
        end else if (cur_c_q >= full_r_q) begin
          cur_c_d = full_l_q;
          cur_r_d = cur_r_q + 16'sd1;
        end else begin
          cur_c_d = cur_c_q + 16'sd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_w_q <= dwcw_pkg::SCREEN_WIDTH_RST;
      screen_h_q <= dwcw_pkg::SCREEN_HEIGHT_RST;
      active_q   <= 1'b0;
      clip_l_q   <= '0;
      clip_t_q   <= '0;
      clip_r_q   <= '0;
      clip_b_q   <= '0;
      full_l_q   <= '0;
      full_r_q   <= '0;
      full_b_q   <= '0;
      cur_c_q    <= '0;
      cur_r_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == dwcw_pkg::CFG_SCREEN_WIDTH) begin
        screen_w_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == dwcw_pkg::CFG_SCREEN_HEIGHT) begin
        screen_h_q <= cfg_data_i;
      end
      active_q <= active_d;
      clip_l_q <= clip_l_d;
      clip_t_q <= clip_t_d;
      clip_r_q <= clip_r_d;
      clip_b_q <= clip_b_d;
      full_l_q <= full_l_d;
      full_r_q <= full_r_d;
      full_b_q <= full_b_d;
      cur_c_q  <= cur_c_d;
      cur_r_q  <= cur_r_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dwcw_fifo.sv
// Short job queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module dwcw_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire dwcw_pkg::job_t    push_job_i,
  input  wire logic              pop_i,
  output dwcw_pkg::job_t         head_job_o,
  output dwcw_pkg::fifo_status_t status_o
);

  dwcw_pkg::job_t mem_q [dwcw_pkg::FIFO_DEPTH];
  logic [dwcw_pkg::FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [dwcw_pkg::FIFO_CNT_BITS-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign status_o.full  = (count_q == dwcw_pkg::FIFO_CNT_BITS'(dwcw_pkg::FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_job_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dwcw_back.sv
// Back part: expands queued jobs into bus words behind an output register.
`timescale 1ns / 1ps
`default_nettype none

module dwcw_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dwcw_pkg::job_t    head_job_i,
  input  wire dwcw_pkg::fifo_status_t fifo_status_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             out_kind_o,
  output logic [15:0]            out_word_o,
  output logic                   out_last_o
);

  logic [3:0]  idx_q, idx_d;
  logic        valid_q;
  logic [1:0]  kind_q;
  logic [15:0] word_q;
  logic        last_q;
  logic        load;
  dwcw_pkg::write_kind_e nxt_kind;
  logic [15:0] nxt_word;
  logic        nxt_last;
  logic [15:0] cs, ce, ps, pe;

  assign cs = 16'(head_job_i.col_start);
  assign ce = 16'(head_job_i.col_end);
  assign ps = 16'(head_job_i.page_start);
  assign pe = 16'(head_job_i.page_end);

  assign load = !valid_q || out_ready_i;

  always_comb begin
    nxt_kind = dwcw_pkg::KIND_CMD;
    nxt_word = '0;
    nxt_last = 1'b0;
    if (head_job_i.kind == dwcw_pkg::JOB_AREA) begin
      nxt_last = (idx_q == dwcw_pkg::AREA_LAST_IDX);
      case (idx_q)
        4'd0: begin
          nxt_word = 16'(dwcw_pkg::CMD_COLUMN_SET);
        end
        4'd1: begin
          nxt_kind = dwcw_pkg::KIND_PARAM;
          nxt_word = {8'h00, cs[15:8]};
        end
        4'd2: begin
          nxt_kind = dwcw_pkg::KIND_PARAM;
          nxt_word = {8'h00, cs[7:0]};
        end
        4'd3: begin
          nxt_kind = dwcw_pkg::KIND_PARAM;
          nxt_word = {8'h00, ce[15:8]};
        end
        4'd4: begin
          nxt_kind = dwcw_pkg::KIND_PARAM;
          nxt_word = {8'h00, ce[7:0]};
        end
        4'd5: begin
          nxt_word = 16'(dwcw_pkg::CMD_PAGE_SET);
        end
        4'd6: begin
          nxt_kind = dwcw_pkg::KIND_PARAM;
          nxt_word = {8'h00, ps[15:8]};
        end
        4'd7: begin
          nxt_kind = dwcw_pkg::KIND_PARAM;
          nxt_word = {8'h00, ps[7:0]};
        end
        4'd8: begin
          nxt_kind = dwcw_pkg::KIND_PARAM;
          nxt_word = {8'h00, pe[15:8]};
        end
        4'd9: begin
          nxt_kind = dwcw_pkg::KIND_PARAM;
          nxt_word = {8'h00, pe[7:0]};
        end
        default: begin
          nxt_word = 16'(dwcw_pkg::CMD_MEMORY_WRITE);
        end
      endcase
    end else if (head_job_i.has_data && idx_q == 4'd0) begin
      nxt_kind = dwcw_pkg::KIND_DATA;
      nxt_word = head_job_i.pixel;
      nxt_last = !head_job_i.has_done;
    end else begin
      nxt_kind = dwcw_pkg::KIND_DONE;
      nxt_last = 1'b1;
    end
  end

  always_comb begin
    pop_o = 1'b0;
    idx_d = idx_q;
    if (load && !fifo_status_i.empty) begin
      if (nxt_last) begin
        pop_o = 1'b1;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= !fifo_status_i.empty;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= nxt_kind;
      word_q <= nxt_word;
      last_q <= nxt_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_word_o  = word_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

>>> tb/sv/display_window_clip_writer_unit_test.sv
// Self-checking testbench for the display window clip writer, with a scoreboard class.
`timescale 1ns / 1ps

module display_window_clip_writer_unit_test;

  // Predicts the panel bus words for every accepted input word and checks them in order.
  class window_scoreboard;
    typedef struct {
      dwcw_pkg::write_kind_e kind;
      logic [15:0] word;
      logic        last;
    } bus_write_t;

    bus_write_t  expected_writes[$];
    int          mismatches;
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    bit          area_open;
    int          clip_l, clip_t, clip_r, clip_b;
    int          full_l, full_r, full_b;
    int          col, row;

    function new();
      screen_width  = dwcw_pkg::SCREEN_WIDTH_RST;
      screen_height = dwcw_pkg::SCREEN_HEIGHT_RST;
      area_open     = 1'b0;
      mismatches    = 0;
      clip_l = 0; clip_t = 0; clip_r = 0; clip_b = 0;
      full_l = 0; full_r = 0; full_b = 0;
      col = 0; row = 0;
    endfunction

    function void set_size(logic idx, logic [11:0] v);
      if (idx == dwcw_pkg::CFG_SCREEN_WIDTH) screen_width = v;
      else screen_height = v;
    endfunction

    // Last usable index of a screen extent: zero acts as one, clamp at 2^COORD_BITS.
    function int span_end(logic [11:0] v);
      int e;
      e = v;
      if (e == 0) e = 1;
      if (e > (1 << dwcw_pkg::COORD_BITS)) e = 1 << dwcw_pkg::COORD_BITS;
      return e - 1;
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction

    function void add_write(dwcw_pkg::write_kind_e kind, logic [15:0] word);
      expected_writes.push_back('{kind, word, 1'b0});
    endfunction

    function void add_window(logic [7:0] cmd, int s, int e);
      logic [15:0] s16, e16;
      s16 = s[15:0];
      e16 = e[15:0];
      add_write(dwcw_pkg::KIND_CMD, {8'h00, cmd});
      add_write(dwcw_pkg::KIND_PARAM, {8'h00, s16[15:8]});
      add_write(dwcw_pkg::KIND_PARAM, {8'h00, s16[7:0]});
      add_write(dwcw_pkg::KIND_PARAM, {8'h00, e16[15:8]});
      add_write(dwcw_pkg::KIND_PARAM, {8'h00, e16[7:0]});
    endfunction

    function void note_input(logic opcode, logic [79:0] data);
      int      wmax, hmax, l, t, r, b, n0;
      shortint sl, st, sr, sbt;
      n0   = expected_writes.size();
      wmax = span_end(screen_width);
      hmax = span_end(screen_height);
      if (opcode == dwcw_pkg::OP_AREA) begin
        sl = data[15:0]; st = data[31:16]; sr = data[47:32]; sbt = data[63:48];
        l = sl; t = st; r = sr; b = sbt;
        area_open = 1'b0;
        // off screen or inverted: drop the area and all of its pixels
        if (!(r < l || b < t || r < 0 || b < 0 || l > wmax || t > hmax)) begin
          clip_l = (l < 0) ? 0 : l;
          clip_t = (t < 0) ? 0 : t;
          clip_r = (r > wmax) ? wmax : r;
          clip_b = (b > hmax) ? hmax : b;
          full_l = l; full_r = r; full_b = b;
          col = l; row = t;
          area_open = 1'b1;
          // mirror both axes
          add_window(dwcw_pkg::CMD_COLUMN_SET, wmax - clip_r, wmax - clip_l);
          add_window(dwcw_pkg::CMD_PAGE_SET, hmax - clip_b, hmax - clip_t);
          add_write(dwcw_pkg::KIND_CMD, {8'h00, dwcw_pkg::CMD_MEMORY_WRITE});
        end
      end else if (area_open) begin
        if (col >= clip_l && col <= clip_r && row >= clip_t && row <= clip_b)
          add_write(dwcw_pkg::KIND_DATA, data[79:64]);
        if (col == full_r && row == full_b) begin
          add_write(dwcw_pkg::KIND_DONE, 16'h0000);
          area_open = 1'b0;
        end else if (col >= full_r) begin
          col = full_l;
          row++;
        end else begin
          col++;
        end
      end
      if (expected_writes.size() > n0)
        expected_writes[expected_writes.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [1:0] kind, logic [15:0] word, logic last);
      bus_write_t exp_w;
      if (expected_writes.size() == 0) begin
        $error("unexpected word: write_kind %0d bus_word 0x%h last_of_run %0b", kind, word, last);
        mismatches++;
        return;
      end
      exp_w = expected_writes.pop_front();
      if (kind !== exp_w.kind) begin
        $error("write_kind: expected %0d, actual %0d", exp_w.kind, kind);
        mismatches++;
      end
      if (word !== exp_w.word) begin
        $error("bus_word: expected 0x%h, actual 0x%h", exp_w.word, word);
        mismatches++;
      end
      if (last !== exp_w.last) begin
        $error("last_of_run: expected %0b, actual %0b", exp_w.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [11:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [15:0] area_left, [31:16] area_top, [47:32] area_right, [63:48] area_bottom,
  // [79:64] pixel_value
  logic [79:0] s_axis_tdata;
  // [0] opcode
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [15:0] bus_word
  logic [15:0] m_axis_tdata;
  // [1:0] write_kind
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  window_scoreboard sb;

  // Idling knobs, changed per phase; zero gives a stretch with no idling.
  int source_gap_pct = 25;
  int sink_stall_pct = 20;
  int sink_hold      = 0;
  // Words of well-formed areas sent so far; bounds each random phase.
  int shaped_words   = 0;

  display_window_clip_writer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 20 ns period
  always #10 clk_i = ~clk_i;

  // Receiver: drop tready in random bursts; change only on the falling edge.
  always @(negedge clk_i) begin
    if (sink_hold != 0) begin
      m_axis_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else if (int'($urandom_range(0, 99)) < sink_stall_pct) begin
      m_axis_tready <= 1'b0;
      sink_hold = $urandom_range(0, 16);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check every word taken on the master side at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // Watchdog: far beyond the slowest legal run (every word stalled, every gap at its longest).
  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Send one word on the slave side. Enter and leave just after a falling edge.
  task automatic push_word(logic opcode, logic [79:0] data);
    int gap;
    if (int'($urandom_range(0, 99)) < source_gap_pct) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= opcode;
    // hold until the block takes the word
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(opcode, data);
    @(negedge clk_i);
  endtask

  // Fill the unused pixel field with noise so every data bit toggles.
  task automatic push_area(int l, int t, int r, int b);
    push_word(dwcw_pkg::OP_AREA, {16'($urandom), 16'(b), 16'(r), 16'(t), 16'(l)});
  endtask

  task automatic push_pixel(logic [15:0] value);
    push_word(dwcw_pkg::OP_PIXEL, {value, 32'($urandom), 32'($urandom)});
  endtask

  // Let all expected words drain, then give the pipeline time to flush words that
  // could still be in flight after an ignored input.
  task automatic drain_and_pause();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  // Write one size register while idle; leaves the write enable low again.
  task automatic write_size(logic idx, logic [11:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_size(idx, value);
    @(negedge clk_i);
  endtask

  // One random frame: mostly a small area, often at a screen edge, and its pixels in row
  // order, now and then cut short; otherwise a single noise word.
  task automatic send_frame();
    int wmax, hmax, w, h, l, t, cnt;
    wmax = sb.span_end(sb.screen_width);
    hmax = sb.span_end(sb.screen_height);
    if ($urandom_range(0, 4) == 0) begin
      push_word(1'($urandom_range(0, 1)), {16'($urandom), 32'($urandom), 32'($urandom)});
      return;
    end
    w = $urandom_range(1, 5);
    h = $urandom_range(1, 4);
    case ($urandom_range(0, 2))
      0: l = int'($urandom_range(0, 6)) - 4;
      1: l = wmax - int'($urandom_range(0, 6)) + 2;
      default: l = $urandom_range(0, wmax);
    endcase
    case ($urandom_range(0, 2))
      0: t = int'($urandom_range(0, 5)) - 3;
      1: t = hmax - int'($urandom_range(0, 5)) + 2;
      default: t = $urandom_range(0, hmax);
    endcase
    push_area(l, t, l + w - 1, t + h - 1);
    cnt = w * h;
    // abandon the area early now and then
    if ($urandom_range(0, 7) == 0) cnt = $urandom_range(0, cnt - 1);
    repeat (cnt) push_pixel(16'($urandom));
    shaped_words += 1 + cnt;
  endtask

  initial begin
    int unsigned phase_w[7];
    int unsigned phase_h[7];
    phase_w = '{800, 1, 0, 2048, 4095, 5, 0};
    phase_h = '{480, 1, 0, 2048, 4095, 3, 0};
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = dwcw_pkg::CFG_SCREEN_WIDTH;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = dwcw_pkg::OP_AREA;
    m_axis_tready = 1'b0;
    sb = new();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset screen size of 800 x 480.
    // Pixel with no area open: ignored.
    push_pixel(16'hFFFF);
    // Wholly left of the screen: dropped, and so are its pixels.
    push_area(-32768, 0, -1, 1);
    push_pixel(16'h0000);
    push_pixel(16'h5A5A);
    // Inverted columns, then areas just past the right and the bottom edge.
    push_area(5, 0, 4, 0);
    push_area(800, 0, 805, 1);
    push_area(0, 480, 1, 482);
    // Two by two in the top left corner, all pixels inside.
    push_area(0, 0, 1, 1);
    push_pixel(16'h0000);
    push_pixel(16'hFFFF);
    push_pixel(16'h8000);
    push_pixel(16'h0001);
    // Straddles the bottom right corner; the last pixel falls outside the clip window.
    push_area(799, 479, 800, 480);
    push_pixel(16'h1234);
    push_pixel(16'hABCD);
    push_pixel(16'h7FFF);
    push_pixel(16'hFFFE);
    // Whole coordinate range, clipped to the screen; abandon it for a new area.
    push_area(-32768, -32768, 32767, 32767);
    push_pixel(16'hAAAA);
    push_pixel(16'h5555);
    push_area(799, 479, 799, 479);
    push_pixel(16'hC3C3);
    drain_and_pause();

    // Random phases, each with its own screen size and idling mix; the last has no idling.
    for (int p = 0; p < 7; p++) begin
      if (p == 6) begin
        phase_w[p] = $urandom_range(1, 64);
        phase_h[p] = $urandom_range(1, 64);
      end
      source_gap_pct = (p == 6 || p % 3 == 1) ? 0 : 25;
      sink_stall_pct = (p == 6 || p % 3 == 2) ? 0 : 20;
      write_size(dwcw_pkg::CFG_SCREEN_WIDTH, 12'(phase_w[p]));
      write_size(dwcw_pkg::CFG_SCREEN_HEIGHT, 12'(phase_h[p]));
      while (shaped_words < 27 * (p + 1)) send_frame();
      drain_and_pause();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/dwcw_pkg.sv
rtl/dwcw_front.sv
rtl/dwcw_fifo.sv
rtl/dwcw_back.sv
rtl/display_window_clip_writer_unit.sv
tb/sv/display_window_clip_writer_unit_test.sv
